/* design/pfx_eval_pkg.sv */
// Shared types, constants and codes of the postfix expression evaluator.
package pfx_eval_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int VALUE_WIDTH = 32;

    // Multiplier bits retired per cycle by the shared arithmetic unit.
    localparam int MUL_DIGIT = 16;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_UNDER = 3'd1;
    localparam logic [2:0] ST_OVER  = 3'd2;
    localparam logic [2:0] ST_DIV0  = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
    } t_out;

    typedef struct packed {
        logic start;
        logic op_div;
    } t_alu_ctrl;

endpackage

/* design/postfix_expression_evaluator_top.sv */
// Top level of the postfix expression evaluator: sequencer, operand stack and result register.
//
//   Channel | Direction | Handshake                | Payload
//   in      | input     | i_in_valid / o_in_stall  | i_in_data  (char_code, last_char)
//   out     | output    | o_out_valid / i_out_stall| o_out_data (value, status)
//
// A space or a digit is done in S_IDLE. + and - are computed in S_EXEC, * then takes up to
// ceil(VALUE_WIDTH/16) multiply steps and / one quotient bit a cycle, and ^ with a
// non-negative exponent runs square-and-multiply on the shared unit: up to 2*VALUE_WIDTH
// multiply passes. The final character then reads the top entry in S_FIN_RD and loads the
// result register in S_FIN, waiting while i_out_stall holds the previous result.
// Reset is synchronous and clears the stack count and the error; stack contents are not
// cleared. A transaction is taken only while o_in_stall is low.
module postfix_expression_evaluator_top #(
    parameter int STACK_DEPTH = pfx_eval_pkg::STACK_DEPTH,
    parameter int VALUE_WIDTH = pfx_eval_pkg::VALUE_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pfx_eval_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pfx_eval_pkg::t_out o_out_data
);

    localparam int W  = VALUE_WIDTH;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RD_TOP  = 4'd1;
    localparam logic [3:0] S_RD_NEXT = 4'd2;
    localparam logic [3:0] S_EXEC    = 4'd3;
    localparam logic [3:0] S_WAIT    = 4'd4;
    localparam logic [3:0] S_POW_CHK = 4'd5;
    localparam logic [3:0] S_POW_ACC = 4'd6;
    localparam logic [3:0] S_POW_SQL = 4'd7;
    localparam logic [3:0] S_POW_SQ  = 4'd8;
    localparam logic [3:0] S_PUSH    = 4'd9;
    localparam logic [3:0] S_FIN_RD  = 4'd10;
    localparam logic [3:0] S_FIN     = 4'd11;

    logic [3:0]  r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [2:0]  r_err, n_err;
    logic [7:0]  r_char, n_char;
    logic        r_last, n_last;
    logic [W-1:0] r_first, n_first;
    logic [W-1:0] r_second, n_second;
    logic [W-1:0] r_res, n_res;
    logic        r_o_valid, n_o_valid;
    pfx_eval_pkg::t_out r_out, n_out;

    logic          w_accept;
    logic          w_is_digit;
    logic [7:0]    w_dig;
    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    logic [W-1:0]  w_ram_wdata;
    logic [AW-1:0] w_ram_raddr;
    logic [W-1:0]  w_rdata;
    logic [CW-1:0] w_cnt_m1;
    logic [CW-1:0] w_cnt_m2;
    logic [2:0]    w_err_u;
    logic [2:0]    w_err_o;
    logic [2:0]    w_err_d;
    logic [3:0]    w_done_state;
    logic          w_out_free;
    logic [63:0]   w_ext;

    pfx_eval_pkg::t_alu_ctrl w_alu_ctrl;
    logic [W-1:0]            w_alu_a;
    logic [W-1:0]            w_alu_b;
    logic                    w_alu_done;
    logic [W-1:0]            w_alu_result;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_out;
    assign w_out_free  = !r_o_valid || !i_out_stall;

    assign w_dig      = i_in_data.char_code - pfx_eval_pkg::CH_ZERO;
    assign w_is_digit = (i_in_data.char_code >= pfx_eval_pkg::CH_ZERO) &&
                        (i_in_data.char_code <= pfx_eval_pkg::CH_NINE);
    assign w_cnt_m1   = r_count - 1'b1;
    assign w_cnt_m2   = r_count - CW'(2);

    // Only the first error of an expression is kept.
    assign w_err_u = (r_err == pfx_eval_pkg::ST_OK) ? pfx_eval_pkg::ST_UNDER : r_err;
    assign w_err_o = (r_err == pfx_eval_pkg::ST_OK) ? pfx_eval_pkg::ST_OVER : r_err;
    assign w_err_d = (r_err == pfx_eval_pkg::ST_OK) ? pfx_eval_pkg::ST_DIV0 : r_err;

    assign w_done_state = r_last ? S_FIN_RD : S_IDLE;
    assign w_ext        = 64'(signed'(w_rdata));

    pfx_eval_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_rdata)
    );

    pfx_eval_alu #(
        .VALUE_WIDTH (W)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_alu_ctrl),
        .i_a      (w_alu_a),
        .i_b      (w_alu_b),
        .o_done   (w_alu_done),
        .o_result (w_alu_result)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_err       = r_err;
        n_char      = r_char;
        n_last      = r_last;
        n_first     = r_first;
        n_second    = r_second;
        n_res       = r_res;
        n_out       = r_out;
        n_o_valid   = r_o_valid && i_out_stall;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_count[AW-1:0];
        w_ram_wdata = r_res;
        w_ram_raddr = w_cnt_m1[AW-1:0];
        w_alu_ctrl  = '0;
        w_alu_a     = w_rdata;
        w_alu_b     = r_first;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_char = i_in_data.char_code;
                    n_last = i_in_data.last_char;
                    if (i_in_data.char_code == pfx_eval_pkg::CH_SPACE) begin
                        n_state = i_in_data.last_char ? S_FIN_RD : S_IDLE;
                    end else if (w_is_digit) begin
                        if (r_count >= CW'(STACK_DEPTH)) begin
                            n_err = w_err_o;
                        end else begin
                            w_ram_we    = 1'b1;
                            w_ram_wdata = W'(w_dig[3:0]);
                            n_count     = r_count + 1'b1;
                        end
                        n_state = i_in_data.last_char ? S_FIN_RD : S_IDLE;
                    end else if (r_count < CW'(2)) begin
                        n_err   = w_err_u;
                        n_state = i_in_data.last_char ? S_FIN_RD : S_IDLE;
                    end else begin
                        n_state = S_RD_TOP;
                    end
                end
            end
            S_RD_TOP: begin
                n_state = S_RD_NEXT;
            end
            S_RD_NEXT: begin
                n_first     = w_rdata;
                w_ram_raddr = w_cnt_m2[AW-1:0];
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                // The second operand arrives from the stack read this cycle.
                n_second = w_rdata;
                n_count  = w_cnt_m2;
                case (r_char)
                    pfx_eval_pkg::CH_PLUS: begin
                        n_res   = w_rdata + r_first;
                        n_state = S_PUSH;
                    end
                    pfx_eval_pkg::CH_MINUS: begin
                        n_res   = w_rdata - r_first;
                        n_state = S_PUSH;
                    end
                    pfx_eval_pkg::CH_STAR: begin
                        w_alu_ctrl.start = 1'b1;
                        n_state          = S_WAIT;
                    end
                    pfx_eval_pkg::CH_SLASH: begin
                        if (r_first == '0) begin
                            n_err   = w_err_d;
                            n_res   = '0;
                            n_state = S_PUSH;
                        end else begin
                            w_alu_ctrl.start  = 1'b1;
                            w_alu_ctrl.op_div = 1'b1;
                            n_state           = S_WAIT;
                        end
                    end
                    pfx_eval_pkg::CH_CARET: begin
                        if (r_first[W-1]) begin
                            // Negative exponent: only a base of 1 or -1 survives.
                            if (w_rdata == W'(1)) begin
                                n_res = W'(1);
                            end else if (w_rdata == '1) begin
                                n_res = r_first[0] ? '1 : W'(1);
                            end else begin
                                n_res = '0;
                            end
                            n_state = S_PUSH;
                        end else begin
                            n_res   = W'(1);
                            n_state = S_POW_CHK;
                        end
                    end
                    default: begin
                        n_state = w_done_state;
                    end
                endcase
            end
            S_WAIT: begin
                if (w_alu_done) begin
                    n_res   = w_alu_result;
                    n_state = S_PUSH;
                end
            end
            S_POW_CHK: begin
                w_alu_a = r_res;
                w_alu_b = r_second;
                if (r_first == '0) begin
                    n_state = S_PUSH;
                end else if (r_first[0]) begin
                    w_alu_ctrl.start = 1'b1;
                    n_state          = S_POW_ACC;
                end else begin
                    n_state = S_POW_SQL;
                end
            end
            S_POW_ACC: begin
                if (w_alu_done) begin
                    n_res   = w_alu_result;
                    n_state = S_POW_SQL;
                end
            end
            S_POW_SQL: begin
                w_alu_a = r_second;
                w_alu_b = r_second;
                if (r_first[W-1:1] == '0) begin
                    n_state = S_PUSH;
                end else begin
                    w_alu_ctrl.start = 1'b1;
                    n_state          = S_POW_SQ;
                end
            end
            S_POW_SQ: begin
                if (w_alu_done) begin
                    n_second = w_alu_result;
                    n_first  = r_first >> 1;
                    n_state  = S_POW_CHK;
                end
            end
            S_PUSH: begin
                w_ram_we = 1'b1;
                n_count  = r_count + 1'b1;
                n_state  = w_done_state;
            end
            S_FIN_RD: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                // The read address stays on the top entry while the result register is busy.
                if (w_out_free) begin
                    n_o_valid   = 1'b1;
                    n_out.value = (r_count != '0) ? w_ext[31:0] : '0;
                    if (r_err != pfx_eval_pkg::ST_OK) begin
                        n_out.status = r_err;
                    end else if (r_count == '0) begin
                        n_out.status = pfx_eval_pkg::ST_EMPTY;
                    end else begin
                        n_out.status = pfx_eval_pkg::ST_OK;
                    end
                    n_count = '0;
                    n_err   = pfx_eval_pkg::ST_OK;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_err     <= pfx_eval_pkg::ST_OK;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_err     <= n_err;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char   <= n_char;
        r_last   <= n_last;
        r_first  <= n_first;
        r_second <= n_second;
        r_res    <= n_res;
        r_out    <= n_out;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count exceeds the stack depth");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_free && !(r_state == S_FIN)) |=> !(o_out_valid && !$past(o_out_valid && i_out_stall)))
        else $error("result loaded outside the final state");

    a_alu_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alu_done |-> (r_state == S_WAIT || r_state == S_POW_ACC || r_state == S_POW_SQ))
        else $error("arithmetic unit finished while the sequencer was not waiting");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == pfx_eval_pkg::ST_EMPTY) |-> o_out_data.value == '0)
        else $error("empty stack transaction carries a nonzero value");
`endif

endmodule

/* design/pfx_eval_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pfx_eval_ram #(
    parameter int WIDTH = pfx_eval_pkg::VALUE_WIDTH,
    parameter int DEPTH = pfx_eval_pkg::STACK_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/pfx_eval_alu.sv */
// Shared iterative unit: digit-serial wrapping multiply and restoring signed divide.
module pfx_eval_alu #(
    parameter int VALUE_WIDTH = pfx_eval_pkg::VALUE_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pfx_eval_pkg::t_alu_ctrl   i_ctrl,
    input  logic [VALUE_WIDTH-1:0]    i_a,
    input  logic [VALUE_WIDTH-1:0]    i_b,
    output logic                      o_done,
    output logic [VALUE_WIDTH-1:0]    o_result
);

    localparam int W   = VALUE_WIDTH;
    localparam int DIG = (W < pfx_eval_pkg::MUL_DIGIT) ? W : pfx_eval_pkg::MUL_DIGIT;
    localparam int CNW = $clog2(W + 1);

    // r_acc holds the partial product or the remainder, r_opa the multiplicand or
    // the divisor magnitude, r_opb the remaining multiplier or the dividend/quotient.
    logic           r_busy;
    logic           r_div;
    logic           r_neg;
    logic [CNW-1:0] r_cnt;
    logic [W-1:0]   r_acc;
    logic [W-1:0]   r_opa;
    logic [W-1:0]   r_opb;

    logic [W+DIG-1:0] w_prod;
    logic [W-1:0]     w_shift;
    logic [W:0]       w_diff;
    logic [W-1:0]     w_abs_a;
    logic [W-1:0]     w_abs_b;

    assign w_prod  = {{DIG{1'b0}}, r_opa} * {{W{1'b0}}, r_opb[DIG-1:0]};
    assign w_shift = {r_acc[W-2:0], r_opb[W-1]};
    assign w_diff  = {1'b0, w_shift} - {1'b0, r_opa};
    assign w_abs_a = i_a[W-1] ? (~i_a + 1'b1) : i_a;
    assign w_abs_b = i_b[W-1] ? (~i_b + 1'b1) : i_b;

    assign o_done   = r_busy && (r_div ? (r_cnt == '0) : (r_opb == '0));
    assign o_result = r_div ? (r_neg ? (~r_opb + 1'b1) : r_opb) : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_ctrl.start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_div <= i_ctrl.op_div;
            r_acc <= '0;
            r_cnt <= CNW'(W);
            r_neg <= i_a[W-1] ^ i_b[W-1];
            if (i_ctrl.op_div) begin
                r_opa <= w_abs_b;
                r_opb <= w_abs_a;
            end else begin
                r_opa <= i_a;
                r_opb <= i_b;
            end
        end else if (r_busy && !o_done) begin
            if (r_div) begin
                r_cnt <= r_cnt - 1'b1;
                if (!w_diff[W]) begin
                    r_acc <= w_diff[W-1:0];
                    r_opb <= {r_opb[W-2:0], 1'b1};
                end else begin
                    r_acc <= w_shift;
                    r_opb <= {r_opb[W-2:0], 1'b0};
                end
            end else begin
                r_acc <= r_acc + w_prod[W-1:0];
                r_opa <= r_opa << DIG;
                r_opb <= r_opb >> DIG;
            end
        end
    end

endmodule

/* verif/postfix_expression_evaluator_checker.sv */
// Checker for the postfix expression evaluator: predicts each result and compares it.
`timescale 1ns / 1ps

module postfix_expression_evaluator_checker
    import pfx_eval_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending
);

    typedef logic [VALUE_WIDTH-1:0] t_word;

    t_word      operand_stack [STACK_DEPTH];
    int         depth;
    logic [2:0] first_error;
    t_out       expected_results [$];
    int         mismatch_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void note_error(input logic [2:0] code);
        if (first_error == ST_OK) begin
            first_error = code;
        end
    endfunction

    function automatic t_word magnitude(input t_word v);
        return v[VALUE_WIDTH-1] ? -v : v;
    endfunction

    // Truncates toward zero; the most negative value over -1 wraps back to itself.
    function automatic t_word quotient(input t_word num, input t_word den);
        t_word q;
        q = magnitude(num) / magnitude(den);
        return (num[VALUE_WIDTH-1] ^ den[VALUE_WIDTH-1]) ? -q : q;
    endfunction

    function automatic t_word power(input t_word base, input t_word ex);
        t_word acc;
        t_word sq;
        acc = 1;
        sq = base;
        if (ex[VALUE_WIDTH-1]) begin
            if (base == 1) return 1;
            if (base == '1) return ex[0] ? '1 : 1;
            return '0;
        end
        for (int i = 0; i < VALUE_WIDTH; i++) begin
            if (ex[i]) acc = acc * sq;
            sq = sq * sq;
        end
        return acc;
    endfunction

    function automatic void apply_char(input logic [7:0] code);
        t_word lhs;
        t_word rhs;
        t_word res;
        if (code == CH_SPACE) return;
        if (code >= CH_ZERO && code <= CH_NINE) begin
            if (depth >= STACK_DEPTH) begin
                note_error(ST_OVER);
            end else begin
                operand_stack[depth] = t_word'(code - CH_ZERO);
                depth++;
            end
            return;
        end
        if (depth < 2) begin
            note_error(ST_UNDER);
            return;
        end
        rhs = operand_stack[depth - 1];
        lhs = operand_stack[depth - 2];
        depth -= 2;
        case (code)
            CH_PLUS:  res = lhs + rhs;
            CH_MINUS: res = lhs - rhs;
            CH_STAR:  res = lhs * rhs;
            CH_SLASH: begin
                if (rhs == '0) begin
                    note_error(ST_DIV0);
                    res = '0;
                end else begin
                    res = quotient(lhs, rhs);
                end
            end
            CH_CARET: res = power(lhs, rhs);
            // An unknown operator consumes both operands and leaves nothing.
            default:  return;
        endcase
        operand_stack[depth] = res;
        depth++;
    endfunction

    function automatic void predict(input t_in item);
        t_out r;
        apply_char(item.char_code);
        if (item.last_char) begin
            r.value = '0;
            if (depth > 0) r.value = $signed(operand_stack[depth - 1]);
            if (first_error != ST_OK) r.status = first_error;
            else if (depth == 0) r.status = ST_EMPTY;
            else r.status = ST_OK;
            expected_results.push_back(r);
            depth = 0;
            first_error = ST_OK;
        end
    endfunction

    task automatic check_result(input t_out got);
        t_out want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result value=%0d status=%0d",
                                      got.value, got.status));
        end else begin
            want = expected_results.pop_front();
            if (got.value !== want.value) begin
                report_mismatch($sformatf("value %0d, expected %0d", got.value, want.value));
            end
            if (got.status !== want.status) begin
                report_mismatch($sformatf("status %0d, expected %0d (value %0d)",
                                          got.status, want.status, want.value));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            depth = 0;
            first_error = ST_OK;
        end else begin
            if (i_out_valid && !i_out_stall) check_result(i_out_data);
            if (i_in_valid && !i_in_stall) predict(i_in_data);
        end
        o_pending <= expected_results.size();
        o_fail_count <= mismatch_count;
    end

endmodule

/* verif/postfix_expression_evaluator_top_tb.sv */
// Testbench top for the postfix expression evaluator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module postfix_expression_evaluator_top_tb;
    import pfx_eval_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 500;
    localparam int RANDOM_ITEMS = 850;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    t_in  in_data;
    logic out_valid;
    logic out_stall;
    t_out out_data;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    bit   gaps_on = 1'b1;

    logic [7:0] expr_chars [$];
    string directed_exprs [6] = '{"34+2-5*", "07-2/", "+50/", "109-^", "23^ ", "12!"};

    postfix_expression_evaluator_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    postfix_expression_evaluator_checker checker_inst (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Mostly short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_operator();
        logic [7:0] code;
        case ($urandom_range(0, 10))
            0, 1:    return CH_PLUS;
            2, 3:    return CH_MINUS;
            4, 5:    return CH_STAR;
            6, 7:    return CH_SLASH;
            8, 9:    return CH_CARET;
            default: begin
                do begin
                    code = 8'($urandom_range(0, 255));
                end while (code == CH_SPACE || (code >= CH_ZERO && code <= CH_NINE));
                return code;
            end
        endcase
    endfunction

    // Called on a falling edge; returns on the falling edge after the transaction.
    task automatic send_char(input logic [7:0] code, input logic last);
        int gap;
        logic [8:0] junk;
        gap = (gaps_on && $urandom_range(0, 1)) ? gap_len() : 0;
        if (gap > 0) begin
            junk = 9'($urandom);
            in_valid <= 1'b0;
            in_data <= junk;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{char_code: code, last_char: last};
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic send_expression(output int counted);
        counted = 0;
        foreach (expr_chars[i]) begin
            send_char(expr_chars[i], i == expr_chars.size() - 1);
            counted++;
        end
    endtask

    task automatic build_expression();
        int kind;
        int len;
        int est_depth;
        int r;
        expr_chars.delete();
        kind = $urandom_range(0, 99);
        if (kind < 62) begin
            // Well formed: operators only once two operands are likely on the stack.
            len = $urandom_range(1, 12);
            est_depth = 0;
            for (int i = 0; i < len; i++) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    expr_chars.push_back(CH_SPACE);
                end else if (est_depth < 2 || r < 55) begin
                    expr_chars.push_back(pick_digit());
                    est_depth++;
                end else begin
                    expr_chars.push_back(pick_operator());
                    est_depth--;
                end
            end
        end else if (kind < 68) begin
            // Push 14 to 19 digits around the stack depth, past it in half the cases.
            len = $urandom_range(14, 19);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) == 0) expr_chars.push_back(CH_SPACE);
                expr_chars.push_back(pick_digit());
            end
            len = $urandom_range(0, 3);
            for (int i = 0; i < len; i++) expr_chars.push_back(pick_operator());
        end else if (kind < 76) begin
            // Negative exponent with a base of 1, -1, a digit or a negative digit.
            r = $urandom_range(0, 3);
            if (r == 0) begin
                expr_chars.push_back(CH_ZERO + 8'd1);
            end else if (r == 1 || r == 3) begin
                expr_chars.push_back(CH_ZERO);
                expr_chars.push_back(r == 1 ? CH_ZERO + 8'd1 : pick_digit());
                expr_chars.push_back(CH_MINUS);
            end else begin
                expr_chars.push_back(pick_digit());
            end
            expr_chars.push_back(CH_ZERO);
            expr_chars.push_back(8'(CH_ZERO + $urandom_range(1, 9)));
            expr_chars.push_back(CH_MINUS);
            expr_chars.push_back(CH_CARET);
        end else if (kind < 80) begin
            // 2 ^ 31 is the most negative value; divide it by -1.
            expr_chars = '{CH_ZERO + 8'd2, CH_ZERO + 8'd8, CH_ZERO + 8'd3, CH_STAR,
                           CH_ZERO + 8'd7, CH_PLUS, CH_CARET,
                           CH_ZERO, CH_ZERO + 8'd1, CH_MINUS, CH_SLASH};
        end else begin
            // Broken sequences and raw bytes.
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                r = $urandom_range(0, 3);
                if (r == 0) expr_chars.push_back(8'($urandom_range(0, 255)));
                else if (r == 1) expr_chars.push_back(pick_digit());
                else if (r == 2) expr_chars.push_back(pick_operator());
                else expr_chars.push_back(CH_SPACE);
            end
        end
    endtask

    initial begin : out_stall_gen
        bit stalling;
        int hold;
        stalling = 1'b0;
        hold = 0;
        out_stall <= 1'b0;
        forever begin
            @(negedge clk);
            if (hold > 0) begin
                hold--;
            end else begin
                stalling = !stalling;
                if (stalling) hold = gap_len();
                else if ($urandom_range(0, 14) == 0) hold = $urandom_range(40, 150);
                else hold = $urandom_range(0, 6);
            end
            out_stall <= stalling;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL postfix_expression_evaluator_top");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int sent;
        int counted;
        sent = 0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_exprs[k]) begin
            expr_chars.delete();
            for (int j = 0; j < directed_exprs[k].len(); j++) begin
                expr_chars.push_back(directed_exprs[k][j]);
            end
            send_expression(counted);
        end

        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) gaps_on = !gaps_on;
            build_expression();
            send_expression(counted);
            sent += counted;
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("PASS postfix_expression_evaluator_top");
        end else begin
            $display("FAIL postfix_expression_evaluator_top");
        end
        $finish;
    end

endmodule
